// ----- rtl/adaptive_damped_position_approach_macros.svh -----
// Assertion macros for the damped position approach block.
// No dependencies; included by files that carry concurrent checks.
`ifndef ADAPTIVE_DAMPED_POSITION_APPROACH_MACROS_SVH
`define ADAPTIVE_DAMPED_POSITION_APPROACH_MACROS_SVH

`ifndef NO_ASSERTIONS
// Property that must hold at every clock edge out of reset.
`define ADPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Antecedent in one cycle, consequent in the next.
`define ADPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ADPA_ASSERT(lbl, prop, msg)
`define ADPA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- rtl/adpa_pkg.sv -----
// Shared widths, constants, state encoding and command structs for the
// damped position approach block. No dependencies.
package adpa_pkg;

  localparam int GOAL_W  = 16;
  localparam int STEP_W  = 16;
  localparam int POS_W   = 32;
  localparam int FRAC_W  = 16;
  localparam int ERR_W   = 34;
  localparam int ABS_W   = 33;
  localparam int GSUM_W  = ABS_W + 1;
  localparam int GAIN_W  = 19;
  localparam int ACC_W   = 53;
  localparam int MPL_W   = 19;
  localparam int REM_W   = 51;
  localparam int QUO_W   = 32;
  localparam int DLT_W   = 45;
  localparam int SUM_W   = 46;
  localparam int CNT_W   = 6;
  localparam int RND_W   = 8;

  localparam logic [GAIN_W-1:0] GAIN_MIN  = 19'd32768;
  localparam logic [GAIN_W-1:0] GAIN_MAX  = 19'd327680;
  localparam logic [GAIN_W-1:0] GAIN_BIAS = 19'd65536;
  localparam logic [MPL_W-1:0]  DAMP_K    = 19'd9830;
  localparam logic [ABS_W-1:0]  ERR_LIM   = 33'd6553;
  localparam logic signed [POS_W-1:0] SPD_LIM = 32'sd13107;
  localparam logic [CNT_W-1:0]  DIV_STEPS = 6'd32;

  typedef enum logic {
    FUNC_START = 1'b0,
    FUNC_TICK  = 1'b1
  } func_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ERR,
    S_ABS,
    S_GAIN,
    S_MUL1,
    S_MUL1W,
    S_MUL2,
    S_MUL2W,
    S_DIV,
    S_DIVW,
    S_DECIDE,
    S_ADV,
    S_ADVW,
    S_RND,
    S_POS,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic                    load;
    logic                    clear;
    logic signed [ACC_W-1:0] mcand;
    logic [MPL_W-1:0]        mplier;
  } mac_cmd_t;

  typedef struct packed {
    logic                    load;
    logic signed [ACC_W-1:0] dividend;
    logic [GAIN_W-1:0]       divisor;
  } div_cmd_t;

endpackage

// ----- rtl/adpa_mac.sv -----
// Bit-serial shift-add multiply-accumulate, one multiplier bit per cycle.
// Depends on adpa_pkg.
module adpa_mac (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  adpa_pkg::mac_cmd_t               cmd_i,
  output logic                             busy_o,
  output logic signed [adpa_pkg::ACC_W-1:0] acc_o
);
  import adpa_pkg::*;

  logic signed [ACC_W-1:0] acc_q;
  logic signed [ACC_W-1:0] mcand_q;
  logic [MPL_W-1:0]        mplier_q;

  // busy until the remaining multiplier bits run out
  assign busy_o = |mplier_q;
  assign acc_o  = acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mplier_q <= '0;
    end else if (cmd_i.load) begin
      mplier_q <= cmd_i.mplier;
    end else if (busy_o) begin
      mplier_q <= mplier_q >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mcand_q <= cmd_i.mcand;
      if (cmd_i.clear) begin
        acc_q <= '0;
      end
    end else if (busy_o) begin
      if (mplier_q[0]) begin
        acc_q <= acc_q + mcand_q;
      end
      mcand_q <= mcand_q <<< 1;
    end
  end

endmodule

// ----- rtl/adpa_div.sv -----
// Restoring divider, one quotient bit per cycle, truncation toward zero
// and saturation to 32-bit signed. Depends on adpa_pkg.
module adpa_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  adpa_pkg::div_cmd_t                cmd_i,
  output logic                              busy_o,
  output logic signed [adpa_pkg::QUO_W-1:0] quo_o
);
  import adpa_pkg::*;

  logic [CNT_W-1:0] cnt_q;
  logic [REM_W-1:0] rem_q;
  logic [REM_W-1:0] dsr_q;
  logic [QUO_W-1:0] quo_q;
  logic             neg_q;
  logic [ACC_W-1:0] mag;
  logic             ge;

  assign busy_o = |cnt_q;
  assign mag    = cmd_i.dividend[ACC_W-1] ? ACC_W'(-cmd_i.dividend) : cmd_i.dividend;
  assign ge     = rem_q >= dsr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.load) begin
      cnt_q <= DIV_STEPS;
    end else if (busy_o) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      neg_q <= cmd_i.dividend[ACC_W-1];
      rem_q <= mag[REM_W-1:0];
      // first trial is the divisor weighted by 2^31: a one there means overflow
      dsr_q <= REM_W'({cmd_i.divisor, {(QUO_W-1){1'b0}}});
    end else if (busy_o) begin
      if (ge) begin
        rem_q <= rem_q - dsr_q;
      end
      dsr_q <= dsr_q >> 1;
      quo_q <= {quo_q[QUO_W-2:0], ge};
    end
  end

  always_comb begin
    if (quo_q[QUO_W-1]) begin
      quo_o = neg_q ? {1'b1, {(QUO_W-1){1'b0}}} : {1'b0, {(QUO_W-1){1'b1}}};
    end else begin
      quo_o = neg_q ? -quo_q : quo_q;
    end
  end

endmodule

// ----- rtl/adaptive_damped_position_approach.sv -----
// Two-axis damped position approach, Q16.16; uses adpa_pkg, adpa_mac, adpa_div, macros.
// For a tick while moving, the time from input transfer to result transfer is set by the
// shared bit-serial MAC (up to 19 + 14 + 16 bits per axis) and the 32-step restoring divider
// per axis. One item at a time: no new input is taken until the last result has been loaded
// into the output register, and a finished item waits while the output is held.
// Reset (async, active low): offsets, velocities, goals zero; loop idle; no result.
`include "adaptive_damped_position_approach_macros.svh"

module adaptive_damped_position_approach (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave side
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // goal_x[15:0], goal_y[31:16], step_size[47:32]
  input  logic [0:0]  s_axis_tuser,   // func[0]
  // master side
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // offset_x[31:0], offset_y[63:32]
  output logic [1:0]  m_axis_tuser    // moving[0], done_res[1]
);
  import adpa_pkg::*;

  state_e state_q, state_d;

  // architectural state
  logic signed [GOAL_W-1:0] goal_x_q, goal_y_q;
  logic signed [POS_W-1:0]  pos_x_q, pos_y_q;
  logic signed [POS_W-1:0]  spd_x_q, spd_y_q;
  logic                     active_q;
  logic                     done_q;
  logic                     ax_q;      // 0 = x axis, 1 = y axis

  // per-tick scratch
  logic [STEP_W-1:0]        step_q;
  logic signed [ERR_W-1:0]  err_q;
  logic [ABS_W-1:0]         abs_q;
  logic [GAIN_W-1:0]        gain_q;
  logic [1:0]               err_ok_q;
  logic [1:0]               spd_ok_q;
  logic signed [DLT_W-1:0]  delta_q;

  // output register
  logic                     out_vld_q;
  logic [POS_W-1:0]         out_x_q, out_y_q;
  logic                     out_mov_q, out_done_q;

  logic                     in_xfer;
  func_e                    in_func;
  logic                     out_load;
  logic                     all_ok;

  logic signed [GOAL_W-1:0] cur_goal;
  logic signed [POS_W-1:0]  cur_pos;
  logic signed [POS_W-1:0]  cur_spd;
  logic [GSUM_W-1:0]        gsum;
  logic [GAIN_W-1:0]        gain_c;
  logic [ACC_W-1:0]         biased;
  logic [SUM_W-1:0]         psum;
  logic                     povf;
  logic signed [POS_W-1:0]  pos_new;

  mac_cmd_t                 mac_cmd;
  logic                     mac_busy;
  logic signed [ACC_W-1:0]  mac_acc;
  div_cmd_t                 div_cmd;
  logic                     div_busy;
  logic signed [QUO_W-1:0]  div_quo;

  adpa_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (mac_cmd),
    .busy_o (mac_busy),
    .acc_o  (mac_acc)
  );

  adpa_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (div_cmd),
    .busy_o (div_busy),
    .quo_o  (div_quo)
  );

  assign in_xfer = s_axis_tvalid && s_axis_tready;
  assign in_func = func_e'(s_axis_tuser[0]);

  // axis select
  assign cur_goal = ax_q ? goal_y_q : goal_x_q;
  assign cur_pos  = ax_q ? pos_y_q  : pos_x_q;
  assign cur_spd  = ax_q ? spd_y_q  : spd_x_q;

  // gain = |err| + |err|/2, clamped to [0.5, 5]
  assign gsum = {1'b0, abs_q} + {2'b00, abs_q[ABS_W-1:1]};
  always_comb begin
    priority if (gsum < GSUM_W'(GAIN_MIN)) begin
      gain_c = GAIN_MIN;
    end else if (gsum > GSUM_W'(GAIN_MAX)) begin
      gain_c = GAIN_MAX;
    end else begin
      gain_c = gsum[GAIN_W-1:0];
    end
  end

  // advance: product / 256 toward zero, then saturating add
  assign biased = mac_acc + {{(ACC_W-RND_W){1'b0}}, {RND_W{mac_acc[ACC_W-1]}}};
  assign psum   = {{(SUM_W-POS_W){cur_pos[POS_W-1]}}, cur_pos}
                + {{(SUM_W-DLT_W){delta_q[DLT_W-1]}}, delta_q};
  assign povf   = !((&psum[SUM_W-1:POS_W-1]) || !(|psum[SUM_W-1:POS_W-1]));
  always_comb begin
    if (povf) begin
      pos_new = psum[SUM_W-1] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end else begin
      pos_new = psum[POS_W-1:0];
    end
  end

  assign all_ok = (&err_ok_q) && (&spd_ok_q);

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    s_axis_tready  = 1'b0;
    out_load       = 1'b0;
    mac_cmd        = '0;
    div_cmd        = '0;
    unique case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          if (in_func == FUNC_TICK && active_q) begin
            state_d = S_ERR;
          end else begin
            state_d = S_EMIT;
          end
        end
      end
      S_ERR:  state_d = S_ABS;
      S_ABS:  state_d = S_GAIN;
      S_GAIN: state_d = S_MUL1;
      S_MUL1: begin
        // gain * velocity
        mac_cmd.load   = 1'b1;
        mac_cmd.clear  = 1'b1;
        mac_cmd.mcand  = {{(ACC_W-POS_W){cur_spd[POS_W-1]}}, cur_spd};
        mac_cmd.mplier = gain_q;
        state_d        = S_MUL1W;
      end
      S_MUL1W: if (!mac_busy) state_d = S_MUL2;
      S_MUL2: begin
        // + 0.15 * error
        mac_cmd.load   = 1'b1;
        mac_cmd.mcand  = {{(ACC_W-ERR_W){err_q[ERR_W-1]}}, err_q};
        mac_cmd.mplier = DAMP_K;
        state_d        = S_MUL2W;
      end
      S_MUL2W: if (!mac_busy) state_d = S_DIV;
      S_DIV: begin
        div_cmd.load     = 1'b1;
        div_cmd.dividend = mac_acc;
        div_cmd.divisor  = gain_q + GAIN_BIAS;
        state_d          = S_DIVW;
      end
      S_DIVW: begin
        if (!div_busy) begin
          state_d = ax_q ? S_DECIDE : S_ERR;
        end
      end
      S_DECIDE: state_d = all_ok ? S_EMIT : S_ADV;
      S_ADV: begin
        mac_cmd.load   = 1'b1;
        mac_cmd.clear  = 1'b1;
        mac_cmd.mcand  = {{(ACC_W-POS_W){cur_spd[POS_W-1]}}, cur_spd};
        mac_cmd.mplier = {{(MPL_W-STEP_W){1'b0}}, step_q};
        state_d        = S_ADVW;
      end
      S_ADVW: if (!mac_busy) state_d = S_RND;
      S_RND:  state_d = S_POS;
      S_POS:  state_d = ax_q ? S_EMIT : S_ADV;
      S_EMIT: begin
        if (!out_vld_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------
  // Architectural state
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      goal_x_q <= '0;
      goal_y_q <= '0;
      pos_x_q  <= '0;
      pos_y_q  <= '0;
      spd_x_q  <= '0;
      spd_y_q  <= '0;
      active_q <= 1'b0;
      done_q   <= 1'b0;
      ax_q     <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            done_q <= 1'b0;
            ax_q   <= 1'b0;
            if (in_func == FUNC_START) begin
              goal_x_q <= s_axis_tdata[15:0];
              goal_y_q <= s_axis_tdata[31:16];
              pos_x_q  <= '0;
              pos_y_q  <= '0;
              spd_x_q  <= '0;
              spd_y_q  <= '0;
              active_q <= 1'b1;
            end
          end
        end
        S_DIVW: begin
          if (!div_busy) begin
            if (ax_q) begin
              spd_y_q <= div_quo;
            end else begin
              spd_x_q <= div_quo;
            end
            ax_q <= ~ax_q;
          end
        end
        S_DECIDE: begin
          // close enough and slow enough: snap to the goal
          if (all_ok) begin
            pos_x_q  <= {goal_x_q, {FRAC_W{1'b0}}};
            pos_y_q  <= {goal_y_q, {FRAC_W{1'b0}}};
            spd_x_q  <= '0;
            spd_y_q  <= '0;
            active_q <= 1'b0;
            done_q   <= 1'b1;
          end
        end
        S_POS: begin
          if (ax_q) begin
            pos_y_q <= pos_new;
          end else begin
            pos_x_q <= pos_new;
          end
          ax_q <= ~ax_q;
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Per-tick scratch registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_xfer) begin
      step_q <= s_axis_tdata[47:32];
    end
    if (state_q == S_ERR) begin
      err_q <= {{2{cur_goal[GOAL_W-1]}}, cur_goal, {FRAC_W{1'b0}}}
             - {{(ERR_W-POS_W){cur_pos[POS_W-1]}}, cur_pos};
    end
    if (state_q == S_ABS) begin
      abs_q <= err_q[ERR_W-1] ? ABS_W'(-err_q) : err_q[ABS_W-1:0];
    end
    if (state_q == S_GAIN) begin
      gain_q         <= gain_c;
      err_ok_q[ax_q] <= abs_q <= ERR_LIM;   // 10*|err| < 1.0
    end
    if (state_q == S_DIVW && !div_busy) begin
      spd_ok_q[ax_q] <= (div_quo >= -SPD_LIM) && (div_quo <= SPD_LIM);  // 5*|v| < 1.0
    end
    if (state_q == S_RND) begin
      delta_q <= biased[ACC_W-1:RND_W];
    end
  end

  // ---------------------------------------------------------------------
  // Output register: holds one result while the next item is worked on
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_x_q    <= pos_x_q;
      out_y_q    <= pos_y_q;
      out_mov_q  <= active_q;
      out_done_q <= done_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_y_q, out_x_q};
  assign m_axis_tuser  = {out_done_q, out_mov_q};

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  `ADPA_ASSERT(a_done_not_moving,
               m_axis_tvalid |-> !(m_axis_tuser[1] && m_axis_tuser[0]),
               "done result still marked moving")
  `ADPA_ASSERT_NEXT(a_snap_to_goal, state_q == S_DECIDE && all_ok,
                    pos_x_q[POS_W-1:FRAC_W] == goal_x_q && pos_y_q[POS_W-1:FRAC_W] == goal_y_q
                    && spd_x_q == 0 && spd_y_q == 0 && !active_q,
                    "snap did not land on goal")
  `ADPA_ASSERT(a_mac_free_on_load, mac_cmd.load |-> !mac_busy, "MAC loaded while busy")
  `ADPA_ASSERT(a_div_free_on_load, div_cmd.load |-> !div_busy, "divider loaded while busy")
  `ADPA_ASSERT_NEXT(a_idle_tick_holds,
                    in_xfer && s_axis_tuser[0] == FUNC_TICK && !active_q,
                    $stable(pos_x_q) && $stable(pos_y_q) && !active_q,
                    "idle tick moved the offsets")

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking bench for adaptive_damped_position_approach: a directed table, then random
// start/tick sequences, each result checked against a Q16.16 bench predictor or a typed row.
// Depends on adpa_pkg (func_e) and the adaptive_damped_position_approach top level.
module testbench;
  import adpa_pkg::*;

  // fixed-point constants of the approach law
  localparam longint Q_ONE   = 64'sd65536;
  localparam longint GAIN_LO = 64'sd32768;   // 0.5
  localparam longint GAIN_HI = 64'sd327680;  // 5.0
  localparam longint DAMPING = 64'sd9830;    // 0.15 in Q0.16

  localparam int ITEMS        = 1000;
  localparam int HOLD_AT      = 300;   // receiver holds off after this many transfers
  localparam int HOLD_CYCLES  = 400;   // longer than a worst-case tick
  localparam int PAUSE_AT     = 600;   // sender drains the block before this transfer
  localparam int QUIET_AT     = 880;   // no idling from here on
  localparam int DRAIN_CYCLES = 250;
  localparam int STALL_LIMIT  = 4000;  // cycles with no transfer on either side
  localparam int N_DIRECTED   = 24;

  // one result transfer, in tdata/tuser field order
  typedef struct packed {
    logic [31:0] offset_x;
    logic [31:0] offset_y;
    logic        moving;
    logic        done_res;
  } report_t;

  typedef struct {
    func_e       func;
    logic [15:0] goal_x;
    logic [15:0] goal_y;
    logic [15:0] step_size;
    bit          typed;     // use the literal below instead of the predictor
    report_t     want;
  } vector_t;

  localparam report_t AT_REST = '{32'd0, 32'd0, 1'b0, 1'b0};
  localparam report_t STARTED = '{32'd0, 32'd0, 1'b1, 1'b0};
  localparam report_t ARRIVED = '{32'd0, 32'd0, 1'b0, 1'b1};

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;   // goal_x[15:0], goal_y[31:16], step_size[47:32]
  logic [0:0]  s_axis_tuser;   // func[0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;   // offset_x[31:0], offset_y[63:32]
  logic [1:0]  m_axis_tuser;   // moving[0], done_res[1]

  // predictor state
  logic signed [15:0] tgt_x, tgt_y;
  logic signed [31:0] cur_x, cur_y;
  logic signed [31:0] vel_x, vel_y;
  logic               in_motion;

  report_t pending_reports[$];
  int      n_sent;
  int      n_fail;
  int      quiet_cycles;
  bit      idle_on;
  bit      rx_hold;

  // directed vectors; tick rows carry junk goals, start rows junk steps
  vector_t directed [N_DIRECTED] = '{
    // tick while idle right after reset
    '{FUNC_TICK,  16'hA5A5, 16'h5A5A, 16'h0100, 1'b1, AT_REST},
    '{FUNC_TICK,  16'hFFFF, 16'h0000, 16'hFFFF, 1'b1, AT_REST},
    // zero goal still starts; the next tick finishes at once
    '{FUNC_START, 16'h0000, 16'h0000, 16'hFFFF, 1'b1, STARTED},
    '{FUNC_TICK,  16'h1234, 16'h8001, 16'h0100, 1'b1, ARRIVED},
    '{FUNC_TICK,  16'h0000, 16'hFFFF, 16'h0000, 1'b1, AT_REST},
    // goal extremes, zero and full-scale steps drive the offsets into saturation
    '{FUNC_START, 16'h7FFF, 16'h8000, 16'h0000, 1'b1, STARTED},
    '{FUNC_TICK,  16'h0000, 16'h0000, 16'h0000, 1'b0, AT_REST},
    '{FUNC_TICK,  16'hFFFF, 16'h0000, 16'hFFFF, 1'b0, AT_REST},
    '{FUNC_TICK,  16'h0000, 16'hFFFF, 16'hFFFF, 1'b0, AT_REST},
    '{FUNC_TICK,  16'h5555, 16'hAAAA, 16'h0001, 1'b0, AT_REST},
    // restart while moving goes back to offset zero
    '{FUNC_START, 16'h0005, 16'hFFFD, 16'h0100, 1'b1, STARTED},
    '{FUNC_TICK,  16'h0000, 16'h0000, 16'h0100, 1'b0, AT_REST},
    '{FUNC_TICK,  16'h0000, 16'h0000, 16'h0080, 1'b0, AT_REST},
    '{FUNC_TICK,  16'h0000, 16'h0000, 16'h0400, 1'b0, AT_REST},
    '{FUNC_TICK,  16'h0000, 16'h0000, 16'h0200, 1'b0, AT_REST},
    '{FUNC_TICK,  16'h0000, 16'h0000, 16'h0100, 1'b0, AT_REST},
    '{FUNC_START, 16'h8000, 16'h7FFF, 16'hFFFF, 1'b1, STARTED},
    '{FUNC_TICK,  16'h0000, 16'h0000, 16'hFFFF, 1'b0, AT_REST},
    '{FUNC_TICK,  16'h0000, 16'h0000, 16'h8000, 1'b0, AT_REST},
    '{FUNC_TICK,  16'h0000, 16'h0000, 16'h0001, 1'b0, AT_REST},
    '{FUNC_START, 16'h0001, 16'h0000, 16'hAAAA, 1'b1, STARTED},
    '{FUNC_TICK,  16'h0000, 16'h0000, 16'h0100, 1'b0, AT_REST},
    '{FUNC_TICK,  16'h0000, 16'h0000, 16'h0100, 1'b0, AT_REST},
    '{FUNC_TICK,  16'h0000, 16'h0000, 16'h0300, 1'b0, AT_REST}
  };

  adaptive_damped_position_approach u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------- predictor

  function automatic logic signed [31:0] clip32(longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return 32'(v);
  endfunction

  function automatic longint mag64(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // goal minus offset in Q16.16, exact
  function automatic longint axis_error(logic signed [15:0] goal, logic signed [31:0] pos);
    return longint'(goal) * Q_ONE - longint'(pos);
  endfunction

  // velocity = (gain*velocity + 0.15*error) / (gain + 1), gain from |error|
  function automatic logic signed [31:0] next_velocity(longint err, logic signed [31:0] vel);
    longint gain;
    longint num;
    gain = mag64(err) + mag64(err) / 2;
    if (gain < GAIN_LO) gain = GAIN_LO;
    if (gain > GAIN_HI) gain = GAIN_HI;
    num = gain * longint'(vel) + DAMPING * err;
    return clip32(num / (gain + Q_ONE));
  endfunction

  // offset plus velocity times Q8.8 step, truncated toward zero, saturated to 32 bits
  function automatic logic signed [31:0] advance_offset(logic signed [31:0] pos,
                                                       logic signed [31:0] vel,
                                                       logic [15:0] step);
    return clip32(longint'(pos) + longint'(vel) * longint'(step) / 256);
  endfunction

  function automatic report_t approach_step(func_e func, logic [15:0] gx, logic [15:0] gy,
                                            logic [15:0] step);
    longint err_x, err_y;
    logic   arrived;
    arrived = 1'b0;
    if (func == FUNC_START) begin
      tgt_x     = gx;
      tgt_y     = gy;
      cur_x     = '0;
      cur_y     = '0;
      vel_x     = '0;
      vel_y     = '0;
      in_motion = 1'b1;
    end else if (in_motion) begin
      err_x = axis_error(tgt_x, cur_x);
      err_y = axis_error(tgt_y, cur_y);
      vel_x = next_velocity(err_x, vel_x);
      vel_y = next_velocity(err_y, vel_y);
      // close enough on both axes: snap to the goal and stop
      if (mag64(err_x) * 10 < Q_ONE && mag64(err_y) * 10 < Q_ONE &&
          mag64(longint'(vel_x)) * 5 < Q_ONE && mag64(longint'(vel_y)) * 5 < Q_ONE) begin
        vel_x     = '0;
        vel_y     = '0;
        cur_x     = {tgt_x, 16'h0000};
        cur_y     = {tgt_y, 16'h0000};
        in_motion = 1'b0;
        arrived   = 1'b1;
      end else begin
        cur_x = advance_offset(cur_x, vel_x, step);
        cur_y = advance_offset(cur_y, vel_y, step);
      end
    end
    return '{cur_x, cur_y, in_motion, arrived};
  endfunction

  // ---------------------------------------------------------------- sender

  // Offers one item from a falling edge and holds it until the transfer.
  task automatic send_item(input func_e func, input logic [15:0] gx, input logic [15:0] gy,
                           input logic [15:0] step, input bit typed, input report_t want);
    report_t predicted;
    @(negedge clk_i);
    if (n_sent == PAUSE_AT) begin
      // let the block run dry before going on
      s_axis_tvalid <= 1'b0;
      do @(negedge clk_i); while (pending_reports.size() != 0);
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {step, gy, gx};
    s_axis_tuser  <= func;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = approach_step(func, gx, gy, step);
    pending_reports.push_back(typed ? want : predicted);
    n_sent++;
    if (n_sent == HOLD_AT) rx_hold = 1'b1;
  endtask

  function automatic logic [15:0] pick_goal();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 7) return 16'(int'($urandom_range(0, 32)) - 16);
    if (sel < 9) return 16'(int'($urandom_range(0, 1200)) - 600);
    return 16'($urandom());
  endfunction

  function automatic logic [15:0] pick_step();
    if ($urandom_range(0, 29) == 0) return 16'($urandom());
    return 16'($urandom_range(128, 1024));
  endfunction

  initial begin
    int ticks;
    int cap;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    tgt_x     = '0;
    tgt_y     = '0;
    cur_x     = '0;
    cur_y     = '0;
    vel_x     = '0;
    vel_y     = '0;
    in_motion = 1'b0;
    n_sent    = 0;
    idle_on   = 1'b1;
    rx_hold   = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed[i])
      send_item(directed[i].func, directed[i].goal_x, directed[i].goal_y,
                directed[i].step_size, directed[i].typed, directed[i].want);

    // mostly complete approaches with random content, some aborted by a
    // restart, the rest raw noise (idle ticks, restarts, full-range fields)
    while (n_sent < ITEMS) begin
      if (n_sent >= QUIET_AT) idle_on = 1'b0;
      if ($urandom_range(0, 3) != 0) begin
        send_item(FUNC_START, pick_goal(), pick_goal(), 16'($urandom()), 1'b0, AT_REST);
        ticks = 0;
        cap   = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 30) : 200;
        while (in_motion && ticks < cap) begin
          send_item(FUNC_TICK, 16'($urandom()), 16'($urandom()), pick_step(), 1'b0, AT_REST);
          ticks++;
        end
      end else begin
        repeat ($urandom_range(1, 6))
          send_item(func_e'($urandom_range(0, 1)), 16'($urandom()), 16'($urandom()),
                    16'($urandom()), 1'b0, AT_REST);
      end
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(negedge clk_i);
    // anything showing up now is unexpected
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (n_fail == 0)
      $display("adaptive_damped_position_approach: match");
    else
      $display("adaptive_damped_position_approach: mismatch");
    $finish;
  end

  // ---------------------------------------------------------------- receiver

  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold) begin
        // long hold-off: the block fills up and stalls its input
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        rx_hold = 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(0, 10)) @(negedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- checking

  initial n_fail = 0;

  always @(posedge clk_i) begin : check_reports
    report_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_reports.size() == 0) begin
        $error("result transfer with nothing pending: tdata %h tuser %b",
               m_axis_tdata, m_axis_tuser);
        n_fail++;
      end else begin
        want = pending_reports.pop_front();
        if (m_axis_tdata[31:0] !== want.offset_x) begin
          $error("offset_x: expected %0d, got %0d",
                 $signed(want.offset_x), $signed(m_axis_tdata[31:0]));
          n_fail++;
        end
        if (m_axis_tdata[63:32] !== want.offset_y) begin
          $error("offset_y: expected %0d, got %0d",
                 $signed(want.offset_y), $signed(m_axis_tdata[63:32]));
          n_fail++;
        end
        if (m_axis_tuser[0] !== want.moving) begin
          $error("moving: expected %b, got %b", want.moving, m_axis_tuser[0]);
          n_fail++;
        end
        if (m_axis_tuser[1] !== want.done_res) begin
          $error("done_res: expected %b, got %b", want.done_res, m_axis_tuser[1]);
          n_fail++;
        end
      end
    end
  end

  // no transfer on either side for too long means the block hung
  initial quiet_cycles = 0;

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("adaptive_damped_position_approach: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
